// File: sv/dlr_pkg.sv
package dlr_pkg;

  localparam int REF_W       = 7;
  localparam int DATA_W      = 32;
  localparam int CNT_OUT_W   = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // input beat layout
  localparam int IN_OP_LSB    = 0;
  localparam int IN_PL_LSB    = 3;
  localparam int IN_REF_LSB   = 5;
  localparam int IN_ABORT_BIT = 12;
  localparam int IN_VAL_LSB   = 13;
  localparam int IN_RD_BIT    = 45;

  // output beat layout
  localparam int OUT_ST_LSB   = 0;
  localparam int OUT_CNT_LSB  = 2;
  localparam int OUT_SRC_BIT  = 9;
  localparam int OUT_VAL_LSB  = 10;
  localparam int OUT_USED_W   = 42;

  typedef enum logic [2:0] {
    OP_APPEND_TREE = 3'd0,
    OP_INSERT      = 3'd1,
    OP_OVERWRITE   = 3'd2,
    OP_INSERT_DUP  = 3'd3,
    OP_ERASE       = 3'd4,
    OP_CLEAR       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    PL_LAST   = 2'd0,
    PL_FIRST  = 2'd1,
    PL_BEFORE = 2'd2,
    PL_AFTER  = 2'd3
  } placement_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADREF = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    K_NOP        = 4'd0,
    K_READ       = 4'd1,
    K_APPEND     = 4'd2,
    K_RESTART    = 4'd3,
    K_OVERWRITE  = 4'd4,
    K_INS_FIRST  = 4'd5,
    K_INS_BEFORE = 4'd6,
    K_INS_AFTER  = 4'd7,
    K_ERASE      = 4'd8,
    K_CLEAR      = 4'd9
  } kind_e;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_FINISH = 1'b1
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic              src;
    logic [REF_W-1:0]  ref_req;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// File: sv/dlr_front.sv
module dlr_front (
  input  logic [dlr_pkg::IN_TDATA_W-1:0] tdata_i,
  output dlr_pkg::cmd_t                  cmd_o
);
  import dlr_pkg::*;

  op_e              op;
  placement_e       placement;
  logic [REF_W-1:0] ref_req;
  logic             aborted;
  logic             read_req;
  kind_e            kind;
  logic             src;

  assign op        = op_e'(tdata_i[IN_OP_LSB +: 3]);
  assign placement = placement_e'(tdata_i[IN_PL_LSB +: 2]);
  assign ref_req   = tdata_i[IN_REF_LSB +: REF_W];
  assign aborted   = tdata_i[IN_ABORT_BIT];
  assign read_req  = tdata_i[IN_RD_BIT];

  always_comb begin
    kind = K_NOP;
    src  = 1'b0;
    priority if (read_req) begin
      kind = K_READ;
    end else if (aborted) begin
      kind = K_NOP;
    end else begin
      unique case (op)
        OP_APPEND_TREE: begin
          kind = K_APPEND;
          src  = 1'b1;
        end
        OP_INSERT:    kind = K_RESTART;
        OP_OVERWRITE: kind = (ref_req == '0) ? K_RESTART : K_OVERWRITE;
        OP_INSERT_DUP: begin
          unique case (placement)
            PL_LAST:   kind = K_APPEND;
            PL_FIRST:  kind = K_INS_FIRST;
            PL_BEFORE: kind = K_INS_BEFORE;
            PL_AFTER:  kind = K_INS_AFTER;
            default:   kind = K_NOP;
          endcase
        end
        OP_ERASE:     kind = (ref_req == '0) ? K_CLEAR : K_ERASE;
        OP_CLEAR:     kind = K_CLEAR;
        default:      kind = K_NOP;
      endcase
    end
  end

  assign cmd_o.kind    = kind;
  assign cmd_o.src     = src;
  assign cmd_o.ref_req = ref_req;
  assign cmd_o.value   = tdata_i[IN_VAL_LSB +: DATA_W];

endmodule

// File: sv/dlr_queue.sv
module dlr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlr_pkg::cmd_t din_i,
  output logic          full_o,
  input  logic          pop_i,
  output dlr_pkg::cmd_t dout_o,
  output logic          valid_o
);
  import dlr_pkg::*;

  cmd_t       mem [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] used_q, used_d;

  assign full_o  = (used_q == 2'd2);
  assign valid_o = (used_q != 2'd0);
  assign dout_o  = mem[rd_q];

  always_comb begin
    wr_d   = push_i ? ~wr_q : wr_q;
    rd_d   = pop_i ? ~rd_q : rd_q;
    used_d = used_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      used_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      used_q <= used_d;
    end
  end

endmodule

// File: sv/dlr_back.sv
module dlr_back #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  dlr_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [dlr_pkg::OUT_TDATA_W-1:0] m_tdata_o
);
  import dlr_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (CW > REF_W) ? CW : REF_W;
  localparam int GB = (IW < 3) ? IW : 3;
  localparam int G  = 1 << GB;
  localparam int NG = (CAPACITY + G - 1) / G;

  // shifting cell row
  logic                  src_q  [CAPACITY];
  logic [VALUE_BITS-1:0] data_q [CAPACITY];
  logic [CW-1:0]         count_q, count_d;

  // first level of the read tree, one slot per group of cells
  logic                  gsrc_q [NG];
  logic [VALUE_BITS-1:0] gdata_q[NG];
  logic                  gsrc_d [NG];
  logic [VALUE_BITS-1:0] gdata_d[NG];

  back_state_e state_q, state_d;
  logic        exec_en, load_out;

  logic [RW-1:0]         ref_x, cnt_x, ref_m1, pos;
  logic [IW-1:0]         pos_i, ridx;
  logic                  ref_ok, is_full;
  logic                  do_ins, do_rem, do_wr, do_restart, do_clear, rd_ok;
  status_e               status;
  logic [VALUE_BITS-1:0] new_val;

  status_e                status_q;
  logic [CNT_OUT_W-1:0]   cnt_snap_q;
  logic                   rd_ok_q;
  logic [IW-1:0]          ridx_q;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   fin_src;
  logic [VALUE_BITS-1:0]  fin_data;

  assign ref_x   = RW'(cmd_i.ref_req);
  assign cnt_x   = RW'(count_q);
  assign ref_m1  = ref_x - RW'(1);
  assign ref_ok  = (ref_x != '0) && (ref_x <= cnt_x);
  assign is_full = (count_q == CW'(CAPACITY));
  assign new_val = VALUE_BITS'(cmd_i.value);
  assign pos_i   = pos[IW-1:0];
  assign ridx    = ref_m1[IW-1:0];

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_wr      = 1'b0;
    do_restart = 1'b0;
    do_clear   = 1'b0;
    rd_ok      = 1'b0;
    status     = ST_OK;
    pos        = '0;
    unique case (cmd_i.kind)
      K_NOP: ;
      K_READ: begin
        if (ref_ok) rd_ok = 1'b1;
        else status = ST_BADREF;
      end
      K_APPEND: begin
        if (is_full) status = ST_FULL;
        else begin
          do_ins = 1'b1;
          pos    = cnt_x;
        end
      end
      K_RESTART: do_restart = 1'b1;
      K_OVERWRITE: begin
        if (ref_ok) begin
          do_wr = 1'b1;
          pos   = ref_m1;
        end else status = ST_BADREF;
      end
      K_INS_FIRST: begin
        if (is_full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      K_INS_BEFORE, K_INS_AFTER: begin
        // reference is checked before fullness
        priority if (!ref_ok) begin
          status = ST_BADREF;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          pos    = (cmd_i.kind == K_INS_AFTER) ? ref_x : ref_m1;
        end
      end
      K_ERASE: begin
        if (ref_ok) begin
          do_rem = 1'b1;
          pos    = ref_m1;
        end else status = ST_BADREF;
      end
      K_CLEAR: do_clear = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (exec_en) begin
      if (do_restart)     count_d = CW'(1);
      else if (do_clear)  count_d = '0;
      else if (do_ins)    count_d = count_q + CW'(1);
      else if (do_rem)    count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_restart) begin
          if (i == 0) begin
            src_q[i]  <= 1'b0;
            data_q[i] <= new_val;
          end
        end else if (do_ins) begin
          if (IW'(i) == pos_i) begin
            src_q[i]  <= cmd_i.src;
            data_q[i] <= new_val;
          end else if (i > 0 && IW'(i) > pos_i) begin
            src_q[i]  <= src_q[(i > 0) ? i - 1 : 0];
            data_q[i] <= data_q[(i > 0) ? i - 1 : 0];
          end
        end else if (do_rem) begin
          if (i < CAPACITY - 1 && IW'(i) >= pos_i) begin
            src_q[i]  <= src_q[(i < CAPACITY - 1) ? i + 1 : i];
            data_q[i] <= data_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end else if (do_wr) begin
          if (IW'(i) == pos_i) begin
            src_q[i]  <= 1'b0;
            data_q[i] <= new_val;
          end
        end
      end
    end
  end

  // pick one cell per group by the low index bits
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gsrc_d[g]  = 1'b0;
      gdata_d[g] = '0;
      for (int j = 0; j < G; j++) begin
        if (g * G + j < CAPACITY) begin
          if ((ridx & IW'(G - 1)) == IW'(j)) begin
            gsrc_d[g]  = src_q[(g * G + j < CAPACITY) ? g * G + j : 0];
            gdata_d[g] = data_q[(g * G + j < CAPACITY) ? g * G + j : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      for (int g = 0; g < NG; g++) begin
        gsrc_q[g]  <= gsrc_d[g];
        gdata_q[g] <= gdata_d[g];
      end
      status_q   <= status;
      cnt_snap_q <= CNT_OUT_W'(count_d);
      rd_ok_q    <= rd_ok;
      ridx_q     <= ridx;
    end
  end

  // second level of the read tree, selects the group
  always_comb begin
    fin_src  = 1'b0;
    fin_data = '0;
    for (int g = 0; g < NG; g++) begin
      if ((ridx_q >> GB) == IW'(g)) begin
        fin_src  = gsrc_q[g];
        fin_data = gdata_q[g];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (cmd_valid_i) state_d = BK_FINISH;
      BK_FINISH: if (!out_valid_q || m_tready_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    exec_en  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE:   exec_en  = cmd_valid_i;
      BK_FINISH: load_out = !out_valid_q || m_tready_i;
      default: ;
    endcase
  end

  assign cmd_pop_o = exec_en;

  always_comb begin
    out_data_d = '0;
    out_data_d[OUT_ST_LSB +: 2]          = status_q;
    out_data_d[OUT_CNT_LSB +: CNT_OUT_W] = cnt_snap_q;
    out_data_d[OUT_SRC_BIT]              = rd_ok_q & fin_src;
    out_data_d[OUT_VAL_LSB +: DATA_W]    = rd_ok_q ? DATA_W'(fin_data) : '0;
    out_valid_d = load_out ? 1'b1 : (m_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

// File: sv/duplicate_list_replay_core.sv
// an accepted input beat is held in the command queue, then executed by the back end,
// whose result beat is registered; the back end takes one item at a time, in its execute
// and finish steps (cell row update plus the two-level registered read tree)
// a two-entry command queue lets the input side run ahead of a stalled output
// reset clears the entry count, the queue and the output valid; cells are not cleared
module duplicate_list_replay_core #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // op, placement, ref_req, aborted, entry_value, read_request (lowest bit up)
  input  logic [dlr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status, entry_count, read_from_tree, read_value (lowest bit up)
  output logic [dlr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dlr_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full, queue_valid, queue_pop, push;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  dlr_front u_front (
    .tdata_i (s_axis_tdata),
    .cmd_o   (front_cmd)
  );

  dlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .dout_o  (queue_cmd),
    .valid_o (queue_valid)
  );

  dlr_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

// File: sv/dlr_checker.sv
module dlr_checker #(
  parameter int CAPACITY = 64
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dlr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dlr_pkg::*;

  localparam logic [CNT_OUT_W-1:0] CAP_CNT = CNT_OUT_W'(CAPACITY);

  logic [1:0] st;
  assign st = m_axis_tdata[OUT_ST_LSB +: 2];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> st != 2'd3)
    else $error("undefined status code");

  // a refused or bad item never carries read data
  a_no_read_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != ST_OK |->
      m_axis_tdata[OUT_VAL_LSB +: DATA_W] == '0 && !m_axis_tdata[OUT_SRC_BIT])
    else $error("read fields set on error status");

  // full is only reported at capacity
  a_full_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_FULL |->
      m_axis_tdata[OUT_CNT_LSB +: CNT_OUT_W] == CAP_CNT)
    else $error("full status below capacity");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("pad bits set in result beat");

endmodule

bind duplicate_list_replay_core dlr_checker #(
  .CAPACITY (CAPACITY)
) u_dlr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
